// ===== rtl/cbg_pkg.sv =====
package cbg_pkg;

    // Sizes of the pixel stream and of the geometry.
    localparam int COMPONENT_BITS = 8;
    localparam int FRACTION_BITS  = 4;
    localparam int COORD_BITS     = 16;

    localparam int WORD_BITS      = 64;
    localparam int HALF_BITS      = 32;
    localparam int CENTER_BITS    = 32;
    localparam int SIZE_BITS      = 16;
    localparam int REGION_BITS    = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int COMPONENTS     = 4;

    // Offsets from the center and the divider that takes them apart.
    localparam int SCALED_BITS = COORD_BITS + FRACTION_BITS;
    localparam int DIFF_BITS   = ((SCALED_BITS > CENTER_BITS) ? SCALED_BITS : CENTER_BITS) + 1;
    localparam int MAG_BITS    = DIFF_BITS - 1;
    localparam int DIV_STAGES  = (MAG_BITS + 1) / 2;
    localparam int DIV_BITS    = 2 * DIV_STAGES;

    // A box size below one pixel is raised to one pixel.
    localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1) << FRACTION_BITS;

    // Register values after reset.
    localparam logic [WORD_BITS-1:0] RST_COLORS_ZERO_ONE    = 64'h0;
    localparam logic [WORD_BITS-1:0] RST_COLORS_TWO_THREE   = 64'h0;
    localparam logic [WORD_BITS-1:0] RST_LINE_COLORS        = 64'h0;
    localparam logic [HALF_BITS-1:0] RST_BOX_SIZE           = 32'h0400_0400;
    localparam logic [WORD_BITS-1:0] RST_PATTERN_CENTER     = 64'h0;
    localparam logic [WORD_BITS-1:0] RST_GRID_LINE_BOUNDS   = 64'h0000_0004_0000_0004;
    localparam logic [WORD_BITS-1:0] RST_CENTER_LINE_BOUNDS = 64'h0004_000C_0004_000C;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COLORS_ZERO_ONE    = 3'd0,
        CFG_COLORS_TWO_THREE   = 3'd1,
        CFG_LINE_COLORS        = 3'd2,
        CFG_BOX_SIZE           = 3'd3,
        CFG_PATTERN_CENTER     = 3'd4,
        CFG_GRID_LINE_BOUNDS   = 3'd5,
        CFG_CENTER_LINE_BOUNDS = 3'd6
    } cbg_cfg_index_t;

    typedef enum logic [REGION_BITS-1:0] {
        REGION_BOX0   = 3'd0,
        REGION_BOX1   = 3'd1,
        REGION_BOX2   = 3'd2,
        REGION_BOX3   = 3'd3,
        REGION_GRID   = 3'd4,
        REGION_CENTER = 3'd5
    } cbg_region_t;

    // Pattern geometry, decoded from the registers.
    typedef struct packed {
        logic signed [CENTER_BITS-1:0] center_x;
        logic signed [CENTER_BITS-1:0] center_y;
        logic [SIZE_BITS-1:0]          size_x;
        logic [SIZE_BITS-1:0]          size_y;
        logic [SIZE_BITS-1:0]          grid_below_x;
        logic [SIZE_BITS-1:0]          grid_above_x;
        logic [SIZE_BITS-1:0]          grid_below_y;
        logic [SIZE_BITS-1:0]          grid_above_y;
        logic [SIZE_BITS-1:0]          ctr_below_x;
        logic [SIZE_BITS-1:0]          ctr_above_x;
        logic [SIZE_BITS-1:0]          ctr_below_y;
        logic [SIZE_BITS-1:0]          ctr_above_y;
    } cbg_geom_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] box01;
        logic [WORD_BITS-1:0] box23;
        logic [WORD_BITS-1:0] lines;
    } cbg_colors_t;

    // One axis on its way through the divider.
    typedef struct packed {
        logic [DIV_BITS-1:0]  mag;
        logic [SIZE_BITS-1:0] rem;
        logic                 par;
        logic                 neg;
        logic                 ctr;
    } cbg_lane_t;

    typedef struct packed {
        cbg_lane_t x;
        cbg_lane_t y;
    } cbg_div_t;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
        logic [COMPONENT_BITS-1:0] alpha;
        logic [REGION_BITS-1:0]    region;
    } cbg_pixel_t;

    // One component of the color in the given half of a register word.
    // A component that starts above the top of the word reads as zero.
    function automatic logic [COMPONENT_BITS-1:0] color_component(
        input logic [WORD_BITS-1:0] word,
        input logic                 half,
        input int                   comp
    );
        int sh;
        sh = HALF_BITS * int'(half) + comp * COMPONENT_BITS;
        if (sh >= WORD_BITS)
        begin
            return '0;
        end
        return COMPONENT_BITS'(word >> sh);
    endfunction

endpackage

// ===== rtl/cbg_in_if.sv =====
interface cbg_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cbg_pkg::COORD_BITS-1:0] x_coord;
    logic signed [cbg_pkg::COORD_BITS-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ===== rtl/cbg_out_if.sv =====
interface cbg_out_if;
    logic                                valid;
    logic                                ready;
    logic [cbg_pkg::COMPONENT_BITS-1:0] red;
    logic [cbg_pkg::COMPONENT_BITS-1:0] green;
    logic [cbg_pkg::COMPONENT_BITS-1:0] blue;
    logic [cbg_pkg::COMPONENT_BITS-1:0] alpha;
    logic [cbg_pkg::REGION_BITS-1:0]    region;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output region, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input region, output ready);
endinterface

// ===== rtl/cbg_front.sv =====
module cbg_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  logic signed [cbg_pkg::COORD_BITS-1:0] x_coord,
    input  logic signed [cbg_pkg::COORD_BITS-1:0] y_coord,
    input  cbg_pkg::cbg_geom_t                    geom,
    output logic                                  dn_valid,
    input  logic                                  dn_ready,
    output cbg_pkg::cbg_div_t                     dn_data
);

    typedef struct packed {
        logic signed [cbg_pkg::DIFF_BITS-1:0] dx;
        logic signed [cbg_pkg::DIFF_BITS-1:0] dy;
    } diff_t;

    logic              s1_vld_reg;
    logic              s2_vld_reg;
    logic              s1_ready;
    logic              s2_ready;
    diff_t             s1_reg;
    diff_t             s1_next;
    cbg_pkg::cbg_div_t s2_reg;
    cbg_pkg::cbg_div_t s2_next;

    // Sign and magnitude of an offset, and whether it lies in the center band.
    function automatic cbg_pkg::cbg_lane_t prep_lane(
        input logic signed [cbg_pkg::DIFF_BITS-1:0] d,
        input logic [cbg_pkg::SIZE_BITS-1:0]        below,
        input logic [cbg_pkg::SIZE_BITS-1:0]        above
    );
        logic signed [cbg_pkg::DIFF_BITS:0]   d_ext;
        logic signed [cbg_pkg::DIFF_BITS:0]   lo;
        logic signed [cbg_pkg::DIFF_BITS:0]   hi;
        logic signed [cbg_pkg::DIFF_BITS-1:0] d_neg;
        logic [cbg_pkg::DIFF_BITS-1:0]        mag_full;
        cbg_pkg::cbg_lane_t                   lane;
        d_ext    = (cbg_pkg::DIFF_BITS + 1)'(d);
        lo       = d_ext + signed'({1'b0, cbg_pkg::DIFF_BITS'(below)});
        hi       = signed'({1'b0, cbg_pkg::DIFF_BITS'(above)});
        d_neg    = -d;
        mag_full = d[cbg_pkg::DIFF_BITS-1] ? unsigned'(d_neg) : unsigned'(d);
        lane.mag = cbg_pkg::DIV_BITS'(mag_full[cbg_pkg::MAG_BITS-1:0]);
        lane.rem = '0;
        lane.par = 1'b0;
        lane.neg = d[cbg_pkg::DIFF_BITS-1];
        lane.ctr = !lo[cbg_pkg::DIFF_BITS] && (d_ext < hi);
        return lane;
    endfunction

    // Ready passes back through every stage combinationally, so that bubbles fill up.
    assign s2_ready = !s2_vld_reg || dn_ready;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign up_ready = s1_ready;

    // First stage: scale the pixel to fixed point and take the offset from the center.
    always_comb
    begin
        s1_next.dx = ((cbg_pkg::DIFF_BITS'(x_coord)) <<< cbg_pkg::FRACTION_BITS)
                     - cbg_pkg::DIFF_BITS'(geom.center_x);
        s1_next.dy = ((cbg_pkg::DIFF_BITS'(y_coord)) <<< cbg_pkg::FRACTION_BITS)
                     - cbg_pkg::DIFF_BITS'(geom.center_y);
    end

    // Second stage: split into sign and magnitude for the divider and test the center band.
    always_comb
    begin
        s2_next.x = prep_lane(s1_reg.dx, geom.ctr_below_x, geom.ctr_above_x);
        s2_next.y = prep_lane(s1_reg.dy, geom.ctr_below_y, geom.ctr_above_y);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_vld_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_vld_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_vld_reg;
    assign dn_data  = s2_reg;

endmodule

// ===== rtl/cbg_divider.sv =====
module cbg_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  cbg_pkg::cbg_div_t             up_data,
    input  logic [cbg_pkg::SIZE_BITS-1:0] size_x,
    input  logic [cbg_pkg::SIZE_BITS-1:0] size_y,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output cbg_pkg::cbg_div_t             dn_data
);

    logic [cbg_pkg::DIV_STAGES-1:0] vld_reg;
    logic [cbg_pkg::DIV_STAGES-1:0] vin;
    logic [cbg_pkg::DIV_STAGES:0]   ready;
    cbg_pkg::cbg_div_t              stage_reg [cbg_pkg::DIV_STAGES];
    cbg_pkg::cbg_div_t              stage_in  [cbg_pkg::DIV_STAGES];
    cbg_pkg::cbg_div_t              stage_next[cbg_pkg::DIV_STAGES];

    // Two restoring division steps: shift in two dividend bits, subtract where it fits.
    // The last quotient bit is the parity of the quotient.
    function automatic cbg_pkg::cbg_lane_t div_step(
        input cbg_pkg::cbg_lane_t            lane,
        input logic [cbg_pkg::SIZE_BITS-1:0] s
    );
        logic [cbg_pkg::SIZE_BITS:0] t;
        cbg_pkg::cbg_lane_t          res;
        res = lane;
        for (int b = 0; b < 2; b++)
        begin
            t       = {res.rem, res.mag[cbg_pkg::DIV_BITS-1]};
            res.mag = res.mag << 1;
            if (t >= {1'b0, s})
            begin
                res.rem = cbg_pkg::SIZE_BITS'(t - {1'b0, s});
                res.par = 1'b1;
            end
            else
            begin
                res.rem = t[cbg_pkg::SIZE_BITS-1:0];
                res.par = 1'b0;
            end
        end
        return res;
    endfunction

    assign ready[cbg_pkg::DIV_STAGES] = dn_ready;
    assign up_ready                   = ready[0];

    for (genvar i = 0; i < cbg_pkg::DIV_STAGES; i++)
    begin : g_stage
        // Stage input comes from the port or from the stage before.
        if (i == 0)
        begin : g_first
            assign vin[i]      = up_valid;
            assign stage_in[i] = up_data;
        end
        else
        begin : g_next
            assign vin[i]      = vld_reg[i-1];
            assign stage_in[i] = stage_reg[i-1];
        end

        assign ready[i] = !vld_reg[i] || ready[i+1];

        always_comb
        begin
            stage_next[i].x = div_step(stage_in[i].x, size_x);
            stage_next[i].y = div_step(stage_in[i].y, size_y);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ready[i])
            begin
                vld_reg[i] <= vin[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[i] && vin[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign dn_valid = vld_reg[cbg_pkg::DIV_STAGES-1];
    assign dn_data  = stage_reg[cbg_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/cbg_select.sv =====
module cbg_select (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  cbg_pkg::cbg_div_t    up_data,
    input  cbg_pkg::cbg_geom_t   geom,
    input  cbg_pkg::cbg_colors_t colors,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output cbg_pkg::cbg_pixel_t  dn_data
);

    typedef struct packed {
        logic [cbg_pkg::SIZE_BITS-1:0] r;
        logic                          par;
        logic                          ctr;
    } rem_lane_t;

    typedef struct packed {
        rem_lane_t x;
        rem_lane_t y;
    } rem_t;

    typedef struct packed {
        logic signed [cbg_pkg::SIZE_BITS:0] delta;
        logic                               par;
        logic                               ctr;
    } off_lane_t;

    typedef struct packed {
        off_lane_t x;
        off_lane_t y;
    } off_t;

    logic                 p1_vld_reg;
    logic                 p2_vld_reg;
    logic                 p3_vld_reg;
    logic                 p1_ready;
    logic                 p2_ready;
    logic                 p3_ready;
    rem_t                 p1_reg;
    rem_t                 p1_next;
    off_t                 p2_reg;
    off_t                 p2_next;
    cbg_pkg::cbg_pixel_t  p3_reg;
    cbg_pkg::cbg_pixel_t  p3_next;
    logic                 grid_x;
    logic                 grid_y;
    cbg_pkg::cbg_region_t region;
    logic [cbg_pkg::WORD_BITS-1:0] word;
    logic                 half;

    // Turn the magnitude remainder into a floor remainder.
    function automatic rem_lane_t fix_rem(
        input cbg_pkg::cbg_lane_t            lane,
        input logic [cbg_pkg::SIZE_BITS-1:0] s
    );
        rem_lane_t o;
        if (lane.neg && (|lane.rem))
        begin
            o.r   = s - lane.rem;
            o.par = !lane.par;
        end
        else
        begin
            o.r   = lane.rem;
            o.par = lane.par;
        end
        o.ctr = lane.ctr;
        return o;
    endfunction

    // Offset from the nearest grid line: the remainder, or one box less past the half.
    function automatic off_lane_t to_offset(
        input rem_lane_t                     lane,
        input logic [cbg_pkg::SIZE_BITS-1:0] s
    );
        off_lane_t o;
        logic      past_half;
        past_half = {lane.r, 1'b0} >= {1'b0, s};
        o.delta   = past_half ? signed'({1'b0, lane.r} - {1'b0, s}) : signed'({1'b0, lane.r});
        o.par     = lane.par;
        o.ctr     = lane.ctr;
        return o;
    endfunction

    // The band reaches from below the line up to, but not including, above it.
    function automatic logic in_band(
        input logic signed [cbg_pkg::SIZE_BITS:0] delta,
        input logic [cbg_pkg::SIZE_BITS-1:0]      below,
        input logic [cbg_pkg::SIZE_BITS-1:0]      above
    );
        logic signed [cbg_pkg::SIZE_BITS+1:0] d_ext;
        logic signed [cbg_pkg::SIZE_BITS+1:0] lo;
        logic signed [cbg_pkg::SIZE_BITS+1:0] hi;
        d_ext = (cbg_pkg::SIZE_BITS + 2)'(delta);
        lo    = d_ext + signed'({2'b00, below});
        hi    = signed'({2'b00, above});
        return !lo[cbg_pkg::SIZE_BITS+1] && (d_ext < hi);
    endfunction

    assign p3_ready = !p3_vld_reg || dn_ready;
    assign p2_ready = !p2_vld_reg || p3_ready;
    assign p1_ready = !p1_vld_reg || p2_ready;
    assign up_ready = p1_ready;

    // First stage: floor remainder and quotient parity.
    always_comb
    begin
        p1_next.x = fix_rem(up_data.x, geom.size_x);
        p1_next.y = fix_rem(up_data.y, geom.size_y);
    end

    // Second stage: signed offset from the nearest grid line.
    always_comb
    begin
        p2_next.x = to_offset(p1_reg.x, geom.size_x);
        p2_next.y = to_offset(p1_reg.y, geom.size_y);
    end

    // Third stage: band tests in priority order, then the box parity.
    always_comb
    begin
        grid_x = in_band(p2_reg.x.delta, geom.grid_below_x, geom.grid_above_x);
        grid_y = in_band(p2_reg.y.delta, geom.grid_below_y, geom.grid_above_y);
        priority if (p2_reg.y.ctr)
        begin
            region = cbg_pkg::REGION_CENTER;
        end
        else if (grid_y)
        begin
            region = cbg_pkg::REGION_GRID;
        end
        else if (p2_reg.x.ctr)
        begin
            region = cbg_pkg::REGION_CENTER;
        end
        else if (grid_x)
        begin
            region = cbg_pkg::REGION_GRID;
        end
        else if (!p2_reg.y.par)
        begin
            region = p2_reg.x.par ? cbg_pkg::REGION_BOX1 : cbg_pkg::REGION_BOX0;
        end
        else
        begin
            region = p2_reg.x.par ? cbg_pkg::REGION_BOX2 : cbg_pkg::REGION_BOX3;
        end
    end

    // Color word and half for the region.
    always_comb
    begin
        unique case (region)
            cbg_pkg::REGION_BOX0:
            begin
                word = colors.box01;
                half = 1'b0;
            end
            cbg_pkg::REGION_BOX1:
            begin
                word = colors.box01;
                half = 1'b1;
            end
            cbg_pkg::REGION_BOX2:
            begin
                word = colors.box23;
                half = 1'b0;
            end
            cbg_pkg::REGION_BOX3:
            begin
                word = colors.box23;
                half = 1'b1;
            end
            cbg_pkg::REGION_GRID:
            begin
                word = colors.lines;
                half = 1'b0;
            end
            default:
            begin
                word = colors.lines;
                half = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        p3_next.red    = cbg_pkg::color_component(word, half, 0);
        p3_next.green  = cbg_pkg::color_component(word, half, 1);
        p3_next.blue   = cbg_pkg::color_component(word, half, 2);
        p3_next.alpha  = cbg_pkg::color_component(word, half, 3);
        p3_next.region = region;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
            begin
                p1_vld_reg <= up_valid;
            end
            if (p2_ready)
            begin
                p2_vld_reg <= p1_vld_reg;
            end
            if (p3_ready)
            begin
                p3_vld_reg <= p2_vld_reg;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (p1_ready && up_valid)
        begin
            p1_reg <= p1_next;
        end
        if (p2_ready && p1_vld_reg)
        begin
            p2_reg <= p2_next;
        end
        if (p3_ready && p2_vld_reg)
        begin
            p3_reg <= p3_next;
        end
    end

    assign dn_valid = p3_vld_reg;
    assign dn_data  = p3_reg;

endmodule

// ===== rtl/checkerboard_grid_pattern_generator.sv =====
// Pipeline: 2 offset stages, 16 divider stages, 3 selection stages.
// Throughput: one pixel per cycle while the output is not stalled; the divider retires two quotient bits per stage.
// A stalled output holds only the last stage; earlier stages keep taking requests
// until the pipeline is full.
// Reset: all pipeline stages empty and the registers return to their defaults.
module checkerboard_grid_pattern_generator (
    input  logic                               clk,
    input  logic                               rst_n,
    cbg_in_if.sink                             pix_in,
    cbg_out_if.source                          pix_out,
    input  logic                               cfg_we,
    input  logic [cbg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cbg_pkg::WORD_BITS-1:0]      cfg_data
);

    logic [cbg_pkg::WORD_BITS-1:0] colors_zero_one_reg;
    logic [cbg_pkg::WORD_BITS-1:0] colors_two_three_reg;
    logic [cbg_pkg::WORD_BITS-1:0] line_colors_reg;
    logic [cbg_pkg::HALF_BITS-1:0] box_size_reg;
    logic [cbg_pkg::WORD_BITS-1:0] pattern_center_reg;
    logic [cbg_pkg::WORD_BITS-1:0] grid_line_bounds_reg;
    logic [cbg_pkg::WORD_BITS-1:0] center_line_bounds_reg;

    cbg_pkg::cbg_geom_t   geom;
    cbg_pkg::cbg_colors_t colors;
    logic [cbg_pkg::SIZE_BITS-1:0] raw_w;
    logic [cbg_pkg::SIZE_BITS-1:0] raw_h;

    logic                 fr_valid;
    logic                 fr_ready;
    cbg_pkg::cbg_div_t    fr_data;
    logic                 dv_valid;
    logic                 dv_ready;
    cbg_pkg::cbg_div_t    dv_data;
    cbg_pkg::cbg_pixel_t  pixel;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_zero_one_reg    <= cbg_pkg::RST_COLORS_ZERO_ONE;
            colors_two_three_reg   <= cbg_pkg::RST_COLORS_TWO_THREE;
            line_colors_reg        <= cbg_pkg::RST_LINE_COLORS;
            box_size_reg           <= cbg_pkg::RST_BOX_SIZE;
            pattern_center_reg     <= cbg_pkg::RST_PATTERN_CENTER;
            grid_line_bounds_reg   <= cbg_pkg::RST_GRID_LINE_BOUNDS;
            center_line_bounds_reg <= cbg_pkg::RST_CENTER_LINE_BOUNDS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbg_pkg::CFG_COLORS_ZERO_ONE:    colors_zero_one_reg    <= cfg_data;
                cbg_pkg::CFG_COLORS_TWO_THREE:   colors_two_three_reg   <= cfg_data;
                cbg_pkg::CFG_LINE_COLORS:        line_colors_reg        <= cfg_data;
                cbg_pkg::CFG_BOX_SIZE:           box_size_reg           <= cfg_data[cbg_pkg::HALF_BITS-1:0];
                cbg_pkg::CFG_PATTERN_CENTER:     pattern_center_reg     <= cfg_data;
                cbg_pkg::CFG_GRID_LINE_BOUNDS:   grid_line_bounds_reg   <= cfg_data;
                cbg_pkg::CFG_CENTER_LINE_BOUNDS: center_line_bounds_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Decode the registers into geometry; box sizes below one pixel count as one.
    assign raw_w = box_size_reg[15:0];
    assign raw_h = box_size_reg[31:16];

    always_comb
    begin
        geom.center_x     = signed'(pattern_center_reg[31:0]);
        geom.center_y     = signed'(pattern_center_reg[63:32]);
        geom.size_x       = (raw_w < cbg_pkg::SIZE_ONE) ? cbg_pkg::SIZE_ONE : raw_w;
        geom.size_y       = (raw_h < cbg_pkg::SIZE_ONE) ? cbg_pkg::SIZE_ONE : raw_h;
        geom.grid_below_x = grid_line_bounds_reg[15:0];
        geom.grid_above_x = grid_line_bounds_reg[31:16];
        geom.grid_below_y = grid_line_bounds_reg[47:32];
        geom.grid_above_y = grid_line_bounds_reg[63:48];
        geom.ctr_below_x  = center_line_bounds_reg[15:0];
        geom.ctr_above_x  = center_line_bounds_reg[31:16];
        geom.ctr_below_y  = center_line_bounds_reg[47:32];
        geom.ctr_above_y  = center_line_bounds_reg[63:48];
        colors.box01      = colors_zero_one_reg;
        colors.box23      = colors_two_three_reg;
        colors.lines      = line_colors_reg;
    end

    // Offsets from the center.
    cbg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_in.valid),
        .up_ready (pix_in.ready),
        .x_coord  (pix_in.x_coord),
        .y_coord  (pix_in.y_coord),
        .geom     (geom),
        .dn_valid (fr_valid),
        .dn_ready (fr_ready),
        .dn_data  (fr_data)
    );

    // Floor division by the box size on both axes.
    cbg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fr_valid),
        .up_ready (fr_ready),
        .up_data  (fr_data),
        .size_x   (geom.size_x),
        .size_y   (geom.size_y),
        .dn_valid (dv_valid),
        .dn_ready (dv_ready),
        .dn_data  (dv_data)
    );

    // Band tests, region and color.
    cbg_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dv_valid),
        .up_ready (dv_ready),
        .up_data  (dv_data),
        .geom     (geom),
        .colors   (colors),
        .dn_valid (pix_out.valid),
        .dn_ready (pix_out.ready),
        .dn_data  (pixel)
    );

    assign pix_out.red    = pixel.red;
    assign pix_out.green  = pixel.green;
    assign pix_out.blue   = pixel.blue;
    assign pix_out.alpha  = pixel.alpha;
    assign pix_out.region = pixel.region;

    // The region code never goes past the center line.
    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> (pix_out.region <= cbg_pkg::REGION_BITS'(cbg_pkg::REGION_CENTER)))
        else $error("region code out of range");

    // A grid-line pixel carries the red and alpha components of the grid line color.
    a_grid_color: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && (pix_out.region == cbg_pkg::REGION_BITS'(cbg_pkg::REGION_GRID)) |->
            (pix_out.red == cbg_pkg::color_component(line_colors_reg, 1'b0, 0)) &&
            (pix_out.alpha == cbg_pkg::color_component(line_colors_reg, 1'b0, 3)))
        else $error("grid line pixel with wrong color");

    // With the output stage empty, the ready chain lets a request in.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_out.valid |-> pix_in.ready)
        else $error("input stalled with an empty output stage");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !pix_out.valid)
        else $error("output valid right after reset");

endmodule
